FILE: rtl/core/rsa_pkg.sv
`default_nettype none

package rsa_pkg;

    // table geometry
    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int TAG_W      = 32;
    localparam int OFF_W      = 16;
    localparam int REQ_W      = 2;
    localparam int ACT_W      = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FLUSH   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END_FN  = 2'd2;

    // result action codes
    localparam logic [ACT_W-1:0] ACT_GRANT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_STORE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DONE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NO_VICT = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             decide;
        logic             emit;
        logic [ACT_W-1:0] action;
        logic             last;
        logic             rr_update;
        logic             fill;
        logic             mark_dirty;
        logic             walk_step;
    } rsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             out_free;
        logic [REQ_W-1:0] req_type;
        logic             hit;
        logic             found;
        logic             evict;
        logic             use_rr;
        logic             victim_dirty;
        logic             wr;
        logic             walk_emit;
        logic             walk_last;
    } rsa_sts_t;

    // lowest set bit of a slot vector
    function automatic logic [SLOT_W-1:0] first_set(input logic [SLOT_COUNT-1:0] vec);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/register_slot_allocator_spill_top.sv
// channel  | signals                                   | direction | handshake
// ---------+-------------------------------------------+-----------+-------------------
// request  | in_valid, in_stall, req_type .. avoid_*   | in        | valid && !in_stall
// result   | out_valid, out_stall, action .. last      | out       | valid && !out_stall
// config   | cfg_valid, cfg_ready, cfg_data            | in        | valid && ready
//
// acquire runs from acceptance to the grant through capture, search,
// optional store back of the victim, then load on a read miss and grant
// flush and end of function walk all 32 slots, one slot a cycle while no
// store back waits on a stalled result, then report done
// the search over the table (tag match, priority pick, round robin) is
// combinational, registered at decide; the walk steps sel through the table
// reset clears valid and dirty marks, the round robin pointer and the mask to
// its default; result stalls hold a walk store back or the sequence in place
`default_nettype none

module register_slot_allocator_spill_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [rsa_pkg::REQ_W-1:0]          req_type,
    input  wire logic [rsa_pkg::TAG_W-1:0]          var_tag,
    input  wire logic                               var_segment,
    input  wire logic signed [rsa_pkg::OFF_W-1:0]   var_offset,
    input  wire logic                               for_write,
    input  wire logic [rsa_pkg::SLOT_W-1:0]         avoid_first,
    input  wire logic [rsa_pkg::SLOT_W-1:0]         avoid_second,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [rsa_pkg::ACT_W-1:0]               action,
    output logic [rsa_pkg::SLOT_W-1:0]              slot_number,
    output logic [rsa_pkg::TAG_W-1:0]               out_tag,
    output logic                                    out_segment,
    output logic signed [rsa_pkg::OFF_W-1:0]        out_offset,
    output logic                                    last,
    // allocatable mask write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rsa_pkg::SLOT_COUNT-1:0]     cfg_data
);

    rsa_pkg::rsa_cmd_t cmd;
    rsa_pkg::rsa_sts_t sts;

    // mask writes are registered and accepted any time
    assign cfg_ready = 1'b1;

    // sequencing: capture, search, spill, fill, walk
    rsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot table, search logic and result register
    rsa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .var_tag      (var_tag),
        .var_segment  (var_segment),
        .var_offset   (var_offset),
        .for_write    (for_write),
        .avoid_first  (avoid_first),
        .avoid_second (avoid_second),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .action       (action),
        .slot_number  (slot_number),
        .out_tag      (out_tag),
        .out_segment  (out_segment),
        .out_offset   (out_offset),
        .last         (last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/rsa_ctrl.sv
`default_nettype none

module rsa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire rsa_pkg::rsa_sts_t sts,
    output rsa_pkg::rsa_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_ACQ    = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_GRANT  = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.req_type == rsa_pkg::REQ_ACQUIRE)
                begin
                    state_next = S_ACQ;
                end
                else if (sts.req_type == rsa_pkg::REQ_FLUSH ||
                         sts.req_type == rsa_pkg::REQ_END_FN)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ACQ:
            begin
                if (sts.hit)
                begin
                    state_next = S_FILL;
                end
                else if (!sts.found)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.action = rsa_pkg::ACT_NO_VICT;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.evict && sts.victim_dirty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.action    = rsa_pkg::ACT_STORE;
                        cmd.rr_update = sts.use_rr;
                        state_next    = S_FILL;
                    end
                end
                else
                begin
                    cmd.rr_update = sts.use_rr;
                    state_next    = S_FILL;
                end
            end
            S_FILL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.hit)
                    begin
                        cmd.mark_dirty = 1'b1;
                        cmd.action     = rsa_pkg::ACT_GRANT;
                        cmd.last       = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.fill = 1'b1;
                        if (sts.wr)
                        begin
                            cmd.action = rsa_pkg::ACT_GRANT;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.action = rsa_pkg::ACT_LOAD;
                            state_next = S_GRANT;
                        end
                    end
                end
            end
            S_GRANT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = rsa_pkg::ACT_GRANT;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (!sts.walk_emit || sts.out_free)
                begin
                    cmd.walk_step = 1'b1;
                    cmd.emit      = sts.walk_emit;
                    cmd.action    = rsa_pkg::ACT_STORE;
                    if (sts.walk_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = rsa_pkg::ACT_DONE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rsa_dp.sv
`default_nettype none

module rsa_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rsa_pkg::rsa_cmd_t                  cmd,
    output rsa_pkg::rsa_sts_t                       sts,
    input  wire logic                               cfg_valid,
    input  wire logic [rsa_pkg::SLOT_COUNT-1:0]     cfg_data,
    input  wire logic [rsa_pkg::REQ_W-1:0]          req_type,
    input  wire logic [rsa_pkg::TAG_W-1:0]          var_tag,
    input  wire logic                               var_segment,
    input  wire logic signed [rsa_pkg::OFF_W-1:0]   var_offset,
    input  wire logic                               for_write,
    input  wire logic [rsa_pkg::SLOT_W-1:0]         avoid_first,
    input  wire logic [rsa_pkg::SLOT_W-1:0]         avoid_second,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [rsa_pkg::ACT_W-1:0]               action,
    output logic [rsa_pkg::SLOT_W-1:0]              slot_number,
    output logic [rsa_pkg::TAG_W-1:0]               out_tag,
    output logic                                    out_segment,
    output logic signed [rsa_pkg::OFF_W-1:0]        out_offset,
    output logic                                    last
);

    localparam logic [rsa_pkg::SLOT_COUNT-1:0] MASK_RESET = 32'h03FF_FF00;

    // configuration and slot table
    logic [rsa_pkg::SLOT_COUNT-1:0] mask_reg;
    logic [rsa_pkg::SLOT_COUNT-1:0] valid_reg;
    logic [rsa_pkg::SLOT_COUNT-1:0] valid_next;
    logic [rsa_pkg::SLOT_COUNT-1:0] dirty_reg;
    logic [rsa_pkg::SLOT_COUNT-1:0] dirty_next;
    logic [rsa_pkg::TAG_W-1:0]      slot_tag_reg [rsa_pkg::SLOT_COUNT];
    logic                           slot_seg_reg [rsa_pkg::SLOT_COUNT];
    logic [rsa_pkg::OFF_W-1:0]      slot_off_reg [rsa_pkg::SLOT_COUNT];
    logic [rsa_pkg::SLOT_W-1:0]     rr_ptr_reg;

    // request held for the whole transaction
    logic [rsa_pkg::REQ_W-1:0]      req_type_reg;
    logic [rsa_pkg::TAG_W-1:0]      req_tag_reg;
    logic                           req_seg_reg;
    logic [rsa_pkg::OFF_W-1:0]      req_off_reg;
    logic                           req_wr_reg;
    logic [rsa_pkg::SLOT_W-1:0]     req_av1_reg;
    logic [rsa_pkg::SLOT_W-1:0]     req_av2_reg;

    // decision results; sel doubles as the walk index
    logic                           hit_reg;
    logic                           found_reg;
    logic                           evict_reg;
    logic                           use_rr_reg;
    logic [rsa_pkg::SLOT_W-1:0]     sel_reg;

    // output register
    logic                           out_valid_reg;
    logic [rsa_pkg::ACT_W-1:0]      out_action_reg;
    logic [rsa_pkg::SLOT_W-1:0]     out_slot_reg;
    logic [rsa_pkg::TAG_W-1:0]      out_tag_reg;
    logic                           out_seg_reg;
    logic [rsa_pkg::OFF_W-1:0]      out_off_reg;
    logic                           out_last_reg;

    logic [rsa_pkg::SLOT_COUNT-1:0]   hit_vec;
    logic [rsa_pkg::SLOT_COUNT-1:0]   free_vec;
    logic [rsa_pkg::SLOT_COUNT-1:0]   avoid_vec;
    logic [rsa_pkg::SLOT_COUNT-1:0]   elig_vec;
    logic [rsa_pkg::SLOT_COUNT-1:0]   clean_vec;
    logic [2*rsa_pkg::SLOT_COUNT-1:0] elig_dbl;
    logic [rsa_pkg::SLOT_COUNT-1:0]   elig_rot;
    logic [rsa_pkg::SLOT_W-1:0]       rr_start;
    logic [rsa_pkg::SLOT_W-1:0]       rr_slot;
    logic [rsa_pkg::SLOT_W-1:0]       pick_slot;
    logic                             walk_emit;
    logic                             walk_clear;
    logic                             out_free;
    logic [rsa_pkg::ACT_W-1:0]        emit_action;
    logic [rsa_pkg::SLOT_W-1:0]       emit_slot;
    logic [rsa_pkg::TAG_W-1:0]        emit_tag;
    logic                             emit_seg;
    logic [rsa_pkg::OFF_W-1:0]        emit_off;

    // parallel match and victim search over the table
    always_comb
    begin
        for (int i = 0; i < rsa_pkg::SLOT_COUNT; i++)
        begin
            hit_vec[i] = mask_reg[i] && valid_reg[i] &&
                         (slot_tag_reg[i] == req_tag_reg) &&
                         (slot_seg_reg[i] == req_seg_reg) &&
                         (slot_off_reg[i] == req_off_reg);
        end
        free_vec  = mask_reg & ~valid_reg;
        avoid_vec = (rsa_pkg::SLOT_COUNT'(1) << req_av1_reg) |
                    (rsa_pkg::SLOT_COUNT'(1) << req_av2_reg);
        elig_vec  = mask_reg & ~avoid_vec;
        clean_vec = elig_vec & ~dirty_reg;
        rr_start  = rr_ptr_reg + 1'b1;
        elig_dbl  = {elig_vec, elig_vec} >> rr_start;
        elig_rot  = elig_dbl[rsa_pkg::SLOT_COUNT-1:0];
        rr_slot   = rr_start + rsa_pkg::first_set(elig_rot);
        if (|hit_vec)
        begin
            pick_slot = rsa_pkg::first_set(hit_vec);
        end
        else if (|free_vec)
        begin
            pick_slot = rsa_pkg::first_set(free_vec);
        end
        else if (|clean_vec)
        begin
            pick_slot = rsa_pkg::first_set(clean_vec);
        end
        else
        begin
            pick_slot = rr_slot;
        end
    end

    // walk decisions for the slot under sel
    always_comb
    begin
        if (req_type_reg == rsa_pkg::REQ_FLUSH)
        begin
            walk_emit  = valid_reg[sel_reg] && dirty_reg[sel_reg];
            walk_clear = 1'b1;
        end
        else
        begin
            walk_emit  = mask_reg[sel_reg] && valid_reg[sel_reg] &&
                         slot_seg_reg[sel_reg] && dirty_reg[sel_reg];
            walk_clear = mask_reg[sel_reg];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.out_free     = out_free;
        sts.req_type     = req_type_reg;
        sts.hit          = hit_reg;
        sts.found        = found_reg;
        sts.evict        = evict_reg;
        sts.use_rr       = use_rr_reg;
        sts.victim_dirty = valid_reg[sel_reg] && dirty_reg[sel_reg];
        sts.wr           = req_wr_reg;
        sts.walk_emit    = walk_emit;
        sts.walk_last    = (sel_reg == rsa_pkg::SLOT_W'(rsa_pkg::SLOT_COUNT - 1));
    end

    // valid and dirty marks
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        if (cmd.fill)
        begin
            valid_next[sel_reg] = 1'b1;
            dirty_next[sel_reg] = req_wr_reg;
        end
        if (cmd.mark_dirty && req_wr_reg)
        begin
            dirty_next[sel_reg] = 1'b1;
        end
        if (cmd.walk_step && walk_clear)
        begin
            valid_next[sel_reg] = 1'b0;
            dirty_next[sel_reg] = 1'b0;
        end
    end

    // result payload
    always_comb
    begin
        emit_action = cmd.action;
        case (cmd.action)
            rsa_pkg::ACT_GRANT,
            rsa_pkg::ACT_LOAD:
            begin
                emit_slot = sel_reg;
                emit_tag  = req_tag_reg;
                emit_seg  = req_seg_reg;
                emit_off  = req_off_reg;
            end
            rsa_pkg::ACT_STORE:
            begin
                emit_slot = sel_reg;
                emit_tag  = slot_tag_reg[sel_reg];
                emit_seg  = slot_seg_reg[sel_reg];
                emit_off  = slot_off_reg[sel_reg];
            end
            default:
            begin
                emit_slot = '0;
                emit_tag  = '0;
                emit_seg  = 1'b0;
                emit_off  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= MASK_RESET;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            rr_ptr_reg    <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            evict_reg     <= 1'b0;
            use_rr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mask_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            if (cmd.rr_update)
            begin
                rr_ptr_reg <= sel_reg;
            end
            if (cmd.decide)
            begin
                hit_reg    <= |hit_vec;
                found_reg  <= (|hit_vec) || (|free_vec) || (|elig_vec);
                evict_reg  <= !(|hit_vec) && !(|free_vec);
                use_rr_reg <= !(|hit_vec) && !(|free_vec) && !(|clean_vec);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            req_tag_reg  <= var_tag;
            req_seg_reg  <= var_segment;
            req_off_reg  <= $unsigned(var_offset);
            req_wr_reg   <= for_write;
            req_av1_reg  <= avoid_first;
            req_av2_reg  <= avoid_second;
        end
        if (cmd.decide)
        begin
            if (req_type_reg == rsa_pkg::REQ_ACQUIRE)
            begin
                sel_reg <= pick_slot;
            end
            else
            begin
                sel_reg <= '0;
            end
        end
        else if (cmd.walk_step)
        begin
            sel_reg <= sel_reg + 1'b1;
        end
        if (cmd.fill)
        begin
            slot_tag_reg[sel_reg] <= req_tag_reg;
            slot_seg_reg[sel_reg] <= req_seg_reg;
            slot_off_reg[sel_reg] <= req_off_reg;
        end
        if (cmd.emit)
        begin
            out_action_reg <= emit_action;
            out_slot_reg   <= emit_slot;
            out_tag_reg    <= emit_tag;
            out_seg_reg    <= emit_seg;
            out_off_reg    <= emit_off;
            out_last_reg   <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_action_reg;
    assign slot_number = out_slot_reg;
    assign out_tag     = out_tag_reg;
    assign out_segment = out_seg_reg;
    assign out_offset  = $signed(out_off_reg);
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    // a dirty mark only ever sits on a valid slot
    a_dirty_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~valid_reg) == '0)
        else $error("dirty mark on an empty slot");

    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result would overwrite a pending result");

    // a filled slot is valid afterwards
    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |=> valid_reg[$past(sel_reg)])
        else $error("filled slot not valid");

    // round robin pointer follows the chosen victim
    a_rr_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rr_update |=> (rr_ptr_reg == $past(sel_reg)))
        else $error("round robin pointer not updated to victim");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_register_slot_allocator_spill_top.sv
module tb_register_slot_allocator_spill_top;

    timeunit 1ns;
    timeprecision 1ps;

    // request code the block does not define, answered by a bare done
    localparam logic [rsa_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // allocatable mask after reset: t0-t9, s0-s7
    localparam logic [rsa_pkg::SLOT_COUNT-1:0] MASK_AT_RESET = 32'h03FF_FF00;

    // variable identities reused by the traffic so that hits and evictions occur
    localparam int POOL_SIZE = 40;

    // cap on printed mismatch lines, every mismatch is still counted
    localparam int REPORT_CAP = 40;

    // one request as the sender sees it; hold makes the sender wait until
    // every outstanding result has come back before presenting it
    typedef struct {
        logic [rsa_pkg::REQ_W-1:0]        kind;
        logic [rsa_pkg::TAG_W-1:0]        tag;
        logic                             seg;
        logic signed [rsa_pkg::OFF_W-1:0] off;
        logic                             wr;
        logic [rsa_pkg::SLOT_W-1:0]       av1;
        logic [rsa_pkg::SLOT_W-1:0]       av2;
        bit                               hold;
    } slot_request_t;

    // one result transaction as the block should emit it
    typedef struct packed {
        logic [rsa_pkg::ACT_W-1:0]        act;
        logic [rsa_pkg::SLOT_W-1:0]       slot;
        logic [rsa_pkg::TAG_W-1:0]        tag;
        logic                             seg;
        logic signed [rsa_pkg::OFF_W-1:0] off;
        logic                             lst;
    } slot_action_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel, every input known from time zero
    logic                             in_valid     = 1'b0;
    logic                             in_stall;
    logic [rsa_pkg::REQ_W-1:0]        req_type     = rsa_pkg::REQ_ACQUIRE;
    logic [rsa_pkg::TAG_W-1:0]        var_tag      = '0;
    logic                             var_segment  = 1'b0;
    logic signed [rsa_pkg::OFF_W-1:0] var_offset   = '0;
    logic                             for_write    = 1'b0;
    logic [rsa_pkg::SLOT_W-1:0]       avoid_first  = '0;
    logic [rsa_pkg::SLOT_W-1:0]       avoid_second = '0;

    // result channel
    logic                             out_valid;
    logic                             out_stall    = 1'b0;
    logic [rsa_pkg::ACT_W-1:0]        action;
    logic [rsa_pkg::SLOT_W-1:0]       slot_number;
    logic [rsa_pkg::TAG_W-1:0]        out_tag;
    logic                             out_segment;
    logic signed [rsa_pkg::OFF_W-1:0] out_offset;
    logic                             last;

    // mask write channel
    logic                             cfg_valid    = 1'b0;
    logic                             cfg_ready;
    logic [rsa_pkg::SLOT_COUNT-1:0]   cfg_data     = '0;

    // requests waiting for the sender, results waiting for the receiver
    slot_request_t req_backlog[$];
    slot_action_t  actions_due[$];

    // the request currently on the request channel
    slot_request_t presented;

    // our own copy of the slot table and its configuration
    logic [rsa_pkg::SLOT_COUNT-1:0]   mask_model = MASK_AT_RESET;
    logic                             held_valid [rsa_pkg::SLOT_COUNT];
    logic                             held_dirty [rsa_pkg::SLOT_COUNT];
    logic [rsa_pkg::TAG_W-1:0]        held_tag   [rsa_pkg::SLOT_COUNT];
    logic                             held_seg   [rsa_pkg::SLOT_COUNT];
    logic signed [rsa_pkg::OFF_W-1:0] held_off   [rsa_pkg::SLOT_COUNT];
    int                               victim_ptr = 0;

    // identity pool
    logic [rsa_pkg::TAG_W-1:0]        pool_tag [POOL_SIZE];
    logic                             pool_seg [POOL_SIZE];
    logic signed [rsa_pkg::OFF_W-1:0] pool_off [POOL_SIZE];

    // idle rates in percent for the sender and the receiver
    int send_idle_pct = 15;
    int recv_idle_pct = 87;

    // bookkeeping; the two result counters move only at clock edges so the
    // sender's drain check never races the monitor
    int results_predicted = 0;
    int results_checked   = 0;
    int requests_accepted = 0;
    int store_backs_seen  = 0;
    int no_victim_seen    = 0;
    int masks_applied     = 0;
    int mismatch_count    = 0;

    register_slot_allocator_spill_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .var_tag      (var_tag),
        .var_segment  (var_segment),
        .var_offset   (var_offset),
        .for_write    (for_write),
        .avoid_first  (avoid_first),
        .avoid_second (avoid_second),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .slot_number  (slot_number),
        .out_tag      (out_tag),
        .out_segment  (out_segment),
        .out_offset   (out_offset),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // one line per mismatch, quiet after the cap
    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
        begin
            $display("%0t mismatch on result %0d: %s", $realtime, results_checked, what);
        end
        mismatch_count++;
    endtask

    // append one expected result transaction
    function automatic void queue_action(input logic [rsa_pkg::ACT_W-1:0] act,
                                         input int slot,
                                         input logic [rsa_pkg::TAG_W-1:0] tag,
                                         input logic seg,
                                         input logic signed [rsa_pkg::OFF_W-1:0] off,
                                         input logic lst);
        slot_action_t a;
        a.act  = act;
        a.slot = rsa_pkg::SLOT_W'(slot);
        a.tag  = tag;
        a.seg  = seg;
        a.off  = off;
        a.lst  = lst;
        actions_due.push_back(a);
    endfunction

    // empty a slot, writing its contents back first if dirty
    function automatic int spill_slot(input int idx);
        int wrote;
        wrote = 0;
        if (held_valid[idx] && held_dirty[idx])
        begin
            queue_action(rsa_pkg::ACT_STORE, idx, held_tag[idx], held_seg[idx],
                         held_off[idx], 1'b0);
            wrote = 1;
        end
        held_valid[idx] = 1'b0;
        held_dirty[idx] = 1'b0;
        return wrote;
    endfunction

    // update the table for one accepted request and queue what it must produce;
    // returns the number of result transactions queued
    function automatic int compute_slot_actions(input slot_request_t r);
        int pick;
        int i;
        int step;
        int cand;
        int made;
        pick = -1;
        made = 0;
        if (r.kind == rsa_pkg::REQ_ACQUIRE)
        begin
            // hit: lowest allocatable slot already holding the variable
            for (i = 0; i < rsa_pkg::SLOT_COUNT && pick < 0; i++)
            begin
                if (mask_model[i] && held_valid[i] && held_tag[i] == r.tag &&
                    held_seg[i] == r.seg && held_off[i] == r.off)
                begin
                    pick = i;
                end
            end
            if (pick < 0)
            begin
                // miss: lowest allocatable free slot
                for (i = 0; i < rsa_pkg::SLOT_COUNT && pick < 0; i++)
                begin
                    if (mask_model[i] && !held_valid[i])
                    begin
                        pick = i;
                    end
                end
                if (pick < 0)
                begin
                    // full: first clean slot that is not avoided
                    for (i = 0; i < rsa_pkg::SLOT_COUNT && pick < 0; i++)
                    begin
                        if (i != r.av1 && i != r.av2 && mask_model[i] && !held_dirty[i])
                        begin
                            pick = i;
                        end
                    end
                    // all dirty: round robin from the slot after the pointer
                    for (step = 1; step <= rsa_pkg::SLOT_COUNT && pick < 0; step++)
                    begin
                        cand = (victim_ptr + step) % rsa_pkg::SLOT_COUNT;
                        if (cand != r.av1 && cand != r.av2 && mask_model[cand])
                        begin
                            pick = cand;
                            victim_ptr = cand;
                        end
                    end
                    if (pick < 0)
                    begin
                        queue_action(rsa_pkg::ACT_NO_VICT, 0, '0, 1'b0, '0, 1'b1);
                        return 1;
                    end
                    made += spill_slot(pick);
                end
                held_valid[pick] = 1'b1;
                held_tag[pick]   = r.tag;
                held_seg[pick]   = r.seg;
                held_off[pick]   = r.off;
                held_dirty[pick] = 1'b0;
                if (!r.wr)
                begin
                    queue_action(rsa_pkg::ACT_LOAD, pick, r.tag, r.seg, r.off, 1'b0);
                    made++;
                end
            end
            if (r.wr)
            begin
                held_dirty[pick] = 1'b1;
            end
            queue_action(rsa_pkg::ACT_GRANT, pick, r.tag, r.seg, r.off, 1'b1);
            return made + 1;
        end
        if (r.kind == rsa_pkg::REQ_FLUSH)
        begin
            // every slot, allocatable or not
            for (i = 0; i < rsa_pkg::SLOT_COUNT; i++)
            begin
                made += spill_slot(i);
            end
        end
        else if (r.kind == rsa_pkg::REQ_END_FN)
        begin
            // globals are written back, frame slots simply dropped
            for (i = 0; i < rsa_pkg::SLOT_COUNT; i++)
            begin
                if (mask_model[i] && held_valid[i])
                begin
                    if (held_seg[i])
                    begin
                        made += spill_slot(i);
                    end
                    else
                    begin
                        held_valid[i] = 1'b0;
                        held_dirty[i] = 1'b0;
                    end
                end
            end
        end
        queue_action(rsa_pkg::ACT_DONE, 0, '0, 1'b0, '0, 1'b1);
        return made + 1;
    endfunction

    // random slot from the current mask, used to aim the avoid fields
    function automatic logic [rsa_pkg::SLOT_W-1:0] mask_slot();
        int probe;
        repeat (64)
        begin
            probe = $urandom_range(rsa_pkg::SLOT_COUNT - 1);
            if (mask_model[probe])
            begin
                return rsa_pkg::SLOT_W'(probe);
            end
        end
        return rsa_pkg::SLOT_W'($urandom_range(rsa_pkg::SLOT_COUNT - 1));
    endfunction

    function automatic slot_request_t acquire_item(input logic [rsa_pkg::TAG_W-1:0] tag,
                                                   input logic seg,
                                                   input logic signed [rsa_pkg::OFF_W-1:0] off,
                                                   input logic wr, input int av1,
                                                   input int av2);
        slot_request_t r;
        r.kind = rsa_pkg::REQ_ACQUIRE;
        r.tag  = tag;
        r.seg  = seg;
        r.off  = off;
        r.wr   = wr;
        r.av1  = rsa_pkg::SLOT_W'(av1);
        r.av2  = rsa_pkg::SLOT_W'(av2);
        r.hold = 1'b0;
        return r;
    endfunction

    // whole-table request; the identity fields carry noise the block must ignore
    function automatic slot_request_t table_item(input logic [rsa_pkg::REQ_W-1:0] kind);
        slot_request_t r;
        r = acquire_item(rsa_pkg::TAG_W'($urandom), 1'($urandom),
                         rsa_pkg::OFF_W'($urandom), 1'($urandom),
                         $urandom_range(31), $urandom_range(31));
        r.kind = kind;
        return r;
    endfunction

    // acquire from the identity pool, or with fully random identity as noise
    function automatic slot_request_t random_acquire(input bit noise);
        slot_request_t r;
        int id;
        id = $urandom_range(POOL_SIZE - 1);
        if (noise)
        begin
            r = acquire_item(rsa_pkg::TAG_W'($urandom), 1'($urandom),
                             rsa_pkg::OFF_W'($urandom), 1'($urandom), 0, 0);
        end
        else
        begin
            r = acquire_item(pool_tag[id], pool_seg[id], pool_off[id], 1'($urandom), 0, 0);
        end
        r.av1 = $urandom_range(1) ? mask_slot() : rsa_pkg::SLOT_W'($urandom_range(31));
        r.av2 = $urandom_range(1) ? mask_slot() : rsa_pkg::SLOT_W'($urandom_range(31));
        return r;
    endfunction

    // function bodies: a run of acquires, mostly closed by end of function,
    // sometimes by a flush, rarely by the unused code
    task automatic queue_random_traffic(input int n_items);
        slot_request_t r;
        int made;
        int run;
        int roll;
        made = 0;
        while (made < n_items)
        begin
            run = $urandom_range(12, 2);
            repeat (run)
            begin
                r = random_acquire($urandom_range(9) == 0);
                r.hold = ($urandom_range(39) == 0);
                req_backlog.push_back(r);
                made++;
            end
            roll = $urandom_range(19);
            if (roll < 10)
            begin
                req_backlog.push_back(table_item(rsa_pkg::REQ_END_FN));
                made++;
            end
            else if (roll < 13)
            begin
                req_backlog.push_back(table_item(rsa_pkg::REQ_FLUSH));
                made++;
            end
            else if (roll == 13)
            begin
                req_backlog.push_back(table_item(REQ_UNUSED));
                made++;
            end
        end
    endtask

    // settle on a falling edge once nothing is queued, presented or outstanding
    task automatic wait_for_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || actions_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // mask write transaction, only issued while the block is idle
    task automatic write_mask(input logic [rsa_pkg::SLOT_COUNT-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        mask_model = value;
        masks_applied++;
        @(negedge clk);
    endtask

    // sender: accept on valid && !stall, then present the next request or idle;
    // valid is held through a stall and never decided from the stall itself
    always @(posedge clk)
    begin
        int  produced;
        bit  go;
        bit  took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                produced = compute_slot_actions(presented);
                results_predicted <= results_predicted + produced;
                requests_accepted++;
            end
            if (!in_valid || took)
            begin
                go = (req_backlog.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                // held request waits for every outstanding result
                if (go && req_backlog[0].hold)
                begin
                    go = !took && (results_predicted == results_checked);
                end
                if (go)
                begin
                    presented = req_backlog.pop_front();
                    req_type     <= presented.kind;
                    var_tag      <= presented.tag;
                    var_segment  <= presented.seg;
                    var_offset   <= presented.off;
                    for_write    <= presented.wr;
                    avoid_first  <= presented.av1;
                    avoid_second <= presented.av2;
                end
                in_valid <= go;
            end
        end
    end

    // receiver: random stalls, every accepted result checked against the oldest
    // expectation field by field
    always @(posedge clk)
    begin
        slot_action_t want;
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked <= results_checked + 1;
            if (action == rsa_pkg::ACT_STORE)
            begin
                store_backs_seen++;
            end
            if (action == rsa_pkg::ACT_NO_VICT)
            begin
                no_victim_seen++;
            end
            if (actions_due.size() == 0)
            begin
                report_mismatch("result with nothing outstanding");
            end
            else
            begin
                want = actions_due.pop_front();
                if (action !== want.act)
                begin
                    report_mismatch($sformatf("action %0d, expected %0d", action, want.act));
                end
                if (slot_number !== want.slot)
                begin
                    report_mismatch($sformatf("slot_number %0d, expected %0d",
                                              slot_number, want.slot));
                end
                if (out_tag !== want.tag)
                begin
                    report_mismatch($sformatf("out_tag %h, expected %h", out_tag, want.tag));
                end
                if (out_segment !== want.seg)
                begin
                    report_mismatch($sformatf("out_segment %0d, expected %0d",
                                              out_segment, want.seg));
                end
                if (out_offset !== want.off)
                begin
                    report_mismatch($sformatf("out_offset %0d, expected %0d",
                                              out_offset, want.off));
                end
                if (last !== want.lst)
                begin
                    report_mismatch($sformatf("last %0d, expected %0d", last, want.lst));
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        slot_request_t r;
        int i;

        // empty table as after reset
        for (i = 0; i < rsa_pkg::SLOT_COUNT; i++)
        begin
            held_valid[i] = 1'b0;
            held_dirty[i] = 1'b0;
            held_tag[i]   = '0;
            held_seg[i]   = 1'b0;
            held_off[i]   = '0;
        end

        // identity pool, the first two at the field extremes
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool_tag[i] = rsa_pkg::TAG_W'($urandom);
            pool_seg[i] = 1'($urandom);
            pool_off[i] = rsa_pkg::OFF_W'($urandom_range(16383) * 4);
        end
        pool_tag[0] = '0;
        pool_seg[0] = 1'b0;
        pool_off[0] = -16'sd32768;
        pool_tag[1] = '1;
        pool_seg[1] = 1'b1;
        pool_off[1] = 16'sd32767;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default mask: load then grant, hits, dirty marking, end of function,
        // unused code, flush of an empty table
        req_backlog.push_back(acquire_item(32'h0000_0000, 1'b0, 16'sd0, 1'b0, 0, 0));
        req_backlog.push_back(acquire_item(32'hFFFF_FFFF, 1'b1, -16'sd32768, 1'b1, 31, 31));
        req_backlog.push_back(acquire_item(32'h0000_0000, 1'b0, 16'sd0, 1'b0, 0, 31));
        req_backlog.push_back(acquire_item(32'h0000_0000, 1'b0, 16'sd0, 1'b1, 31, 0));
        req_backlog.push_back(acquire_item(32'hA5A5_A5A5, 1'b1, 16'sd32767, 1'b0, 8, 9));
        req_backlog.push_back(acquire_item(32'h5A5A_5A5A, 1'b0, 16'sd4, 1'b1, 10, 11));
        req_backlog.push_back(table_item(rsa_pkg::REQ_END_FN));
        req_backlog.push_back(table_item(REQ_UNUSED));
        req_backlog.push_back(table_item(rsa_pkg::REQ_FLUSH));
        wait_for_idle();

        // two slots: clean victim, round robin victim with store back,
        // both slots avoided so no victim exists
        write_mask(32'h0000_0003);
        req_backlog.push_back(acquire_item(32'h11, 1'b0, 16'sd8, 1'b1, 0, 0));
        req_backlog.push_back(acquire_item(32'h22, 1'b1, 16'sd12, 1'b0, 0, 0));
        req_backlog.push_back(acquire_item(32'h33, 1'b0, 16'sd16, 1'b1, 1, 1));
        req_backlog.push_back(acquire_item(32'h44, 1'b0, 16'sd20, 1'b0, 0, 1));
        req_backlog.push_back(acquire_item(32'h44, 1'b0, 16'sd20, 1'b0, 0, 0));
        req_backlog.push_back(acquire_item(32'h44, 1'b0, 16'sd20, 1'b1, 0, 0));
        req_backlog.push_back(acquire_item(32'h55, 1'b1, 16'sd24, 1'b1, 2, 3));
        wait_for_idle();

        // first and last slot: round robin wraps, a stale slot outside the mask
        // is ignored by end of function
        write_mask(32'h8000_0001);
        req_backlog.push_back(acquire_item(32'h66, 1'b0, 16'sd0, 1'b1, 5, 5));
        req_backlog.push_back(acquire_item(32'h77, 1'b1, -16'sd4, 1'b1, 5, 5));
        req_backlog.push_back(acquire_item(32'h88, 1'b0, -16'sd8, 1'b1, 5, 5));
        req_backlog.push_back(table_item(rsa_pkg::REQ_END_FN));
        wait_for_idle();

        // nothing allocatable: acquire has no victim, flush still writes back
        // slots outside the mask
        write_mask(32'h0000_0000);
        req_backlog.push_back(acquire_item(32'h99, 1'b1, 16'sd28, 1'b1, 0, 0));
        req_backlog.push_back(table_item(rsa_pkg::REQ_FLUSH));
        req_backlog.push_back(table_item(rsa_pkg::REQ_END_FN));
        wait_for_idle();

        // random traffic, sender mostly busy, receiver mostly stalled
        write_mask(32'hFFFF_FFFF);
        queue_random_traffic(70);
        wait_for_idle();

        // swap the idle rates, few slots with wraparound
        send_idle_pct = 87;
        recv_idle_pct = 15;
        write_mask(32'h8000_00F1);
        queue_random_traffic(60);
        wait_for_idle();

        // back to back, default mask; the first request waits out a full drain
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mask(MASK_AT_RESET);
        r = random_acquire(1'b0);
        r.hold = 1'b1;
        req_backlog.push_back(r);
        queue_random_traffic(60);
        wait_for_idle();

        // trailing window for stray results
        repeat (60) @(posedge clk);

        $display("covered %0d requests and %0d results across %0d mask settings",
                 requests_accepted, results_checked, masks_applied);
        $display("store-backs %0d, acquires with no victim %0d",
                 store_backs_seen, no_victim_seen);
        if (mismatch_count == 0)
        begin
            $display("[register_slot_allocator_spill_top] OK");
        end
        else
        begin
            $display("[register_slot_allocator_spill_top] ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", actions_due.size());
        $display("[register_slot_allocator_spill_top] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rsa_pkg.sv
rtl/core/rsa_ctrl.sv
rtl/core/rsa_dp.sv
rtl/core/register_slot_allocator_spill_top.sv
verif/tb_register_slot_allocator_spill_top.sv
